>>> hw/rtl/ctse_pkg.sv
// Shared types, codes and helpers for the calendar time set editor.
package ctse_pkg;

  localparam int NumFields   = 7;
  localparam int FieldW      = 7;
  localparam int SelW        = 3;
  localparam int PeriodW     = 16;
  localparam int InDataW     = 40;
  localparam int OutDataW    = 56;

  localparam logic [PeriodW-1:0] BlinkPeriodRst = 16'd500;

  localparam logic [SelW-1:0] FldYear    = 3'd0;
  localparam logic [SelW-1:0] FldMonth   = 3'd1;
  localparam logic [SelW-1:0] FldDay     = 3'd2;
  localparam logic [SelW-1:0] FldHour    = 3'd3;
  localparam logic [SelW-1:0] FldMinute  = 3'd4;
  localparam logic [SelW-1:0] FldSecond  = 3'd5;
  localparam logic [SelW-1:0] FldWeekday = 3'd6;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_MODE   = 3'd1,
    ACT_SELECT = 3'd2,
    ACT_UP     = 3'd3,
    ACT_DOWN   = 3'd4,
    ACT_LOAD   = 3'd5
  } action_t;

  // index 0 year through 6 weekday
  typedef logic [NumFields-1:0][FieldW-1:0] fields_t;

  // working value of a field during an edit: 7 bits plus carry and sign
  typedef logic signed [FieldW+1:0] wfield_t;

  // days in month, 0 when the month is out of range
  function automatic logic [4:0] day_limit(input wfield_t month, input logic [1:0] year_lo);
    logic [4:0] lim;
    lim = 5'd0;
    if (month == 9'sd1 || month == 9'sd3 || month == 9'sd5 || month == 9'sd7 ||
        month == 9'sd8 || month == 9'sd10 || month == 9'sd12) begin
      lim = 5'd31;
    end else if (month == 9'sd4 || month == 9'sd6 || month == 9'sd9 || month == 9'sd11) begin
      lim = 5'd30;
    end else if (month == 9'sd2) begin
      lim = (year_lo == 2'd0) ? 5'd29 : 5'd28;
    end
    return lim;
  endfunction

endpackage

>>> hw/rtl/ctse_edit.sv
// Up/down edit of the selected field with per-field wrap checks.
module ctse_edit (
  input  ctse_pkg::fields_t         fields_i,
  input  logic [ctse_pkg::SelW-1:0] sel_i,
  input  logic                      down_i,
  output ctse_pkg::fields_t         fields_o
);
  import ctse_pkg::*;

  wfield_t    f [NumFields];
  logic [4:0] lim;
  wfield_t    lim_w;

  always_comb begin
    for (int i = 0; i < NumFields; i++) begin
      f[i] = wfield_t'({2'b00, fields_i[i]});
    end
    if (down_i) begin
      f[sel_i] = f[sel_i] - 9'sd1;
    end else begin
      f[sel_i] = f[sel_i] + 9'sd1;
    end

    lim   = 5'd0;
    lim_w = '0;
    if (!down_i) begin
      if (f[FldYear] > 9'sd99) f[FldYear] = 9'sd0;
      if (f[FldMonth] > 9'sd12) f[FldMonth] = 9'sd1;
      lim   = day_limit(f[FldMonth], f[FldYear][1:0]);
      lim_w = wfield_t'({4'b0000, lim});
      if (lim != 5'd0 && f[FldDay] > lim_w) f[FldDay] = 9'sd1;
      if (f[FldHour] > 9'sd23) f[FldHour] = 9'sd0;
      if (f[FldMinute] > 9'sd59) f[FldMinute] = 9'sd0;
      if (f[FldSecond] > 9'sd59) f[FldSecond] = 9'sd0;
      if (f[FldWeekday] > 9'sd7) f[FldWeekday] = 9'sd1;
    end else begin
      if (f[FldYear] < 9'sd0) f[FldYear] = 9'sd99;
      if (f[FldMonth] < 9'sd1) f[FldMonth] = 9'sd12;
      lim   = day_limit(f[FldMonth], f[FldYear][1:0]);
      lim_w = wfield_t'({4'b0000, lim});
      if (lim != 5'd0) begin
        if (f[FldDay] < 9'sd1) begin
          f[FldDay] = lim_w;
        end else if (f[FldDay] > lim_w) begin
          f[FldDay] = 9'sd1;
        end
      end
      if (f[FldHour] < 9'sd0) f[FldHour] = 9'sd23;
      if (f[FldMinute] < 9'sd0) f[FldMinute] = 9'sd59;
      if (f[FldSecond] < 9'sd0) f[FldSecond] = 9'sd59;
      if (f[FldWeekday] < 9'sd1) f[FldWeekday] = 9'sd7;
    end

    for (int i = 0; i < NumFields; i++) begin
      fields_o[i] = f[i][FieldW-1:0];
    end
  end

endmodule

>>> hw/rtl/calendar_time_set_editor_core.sv
// Top level of the calendar time set editor.
//
// Input beats: in_tuser carries the action (tick, mode, select, up, down,
// load); in_tdata carries the time read from the clock chip, used by load.
// Every accepted beat yields exactly one output beat showing the mode,
// selector, blink flag, all seven fields and the write-to-chip pulse as
// they stand after that beat.
// Output: the result is registered and appears in the cycle after acceptance.
// Throughput: one beat per cycle unless stalled; state and result register
// update in the same edge, so the next beat sees the new state with no bubble.
// Stall: the single output register holds its beat; in_tready drops only
// while that beat is waiting and out_tready is low.
// cfg_data sets the blink period in ticks; cfg_ready is always high.
// Reset: fields, mode, selector, blink flag and tick count clear, blink
// period returns to 500, no output beat pending.
module calendar_time_set_editor_core (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_tvalid,
  output logic                              in_tready,
  // load_year[6:0], load_month[10:7], load_day[15:11], load_hour[20:16],
  // load_minute[26:21], load_second[32:27], load_weekday[35:33], zero pad
  input  logic [ctse_pkg::InDataW-1:0]      in_tdata,
  // action[2:0]
  input  logic [2:0]                        in_tuser,

  output logic                              out_tvalid,
  input  logic                              out_tready,
  // set_mode[0], selected_field[3:1], blink_on[4], year[11:5], month[18:12],
  // day[25:19], hour[32:26], minute[39:33], second[46:40], weekday[53:47],
  // write_to_chip[54], zero pad[55]
  output logic [ctse_pkg::OutDataW-1:0]     out_tdata,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ctse_pkg::PeriodW-1:0]      cfg_data
);
  import ctse_pkg::*;

  logic [PeriodW-1:0]  period_r;
  fields_t             fields_r, fields_nxt;
  logic                mode_r, mode_nxt;
  logic [SelW-1:0]     sel_r, sel_nxt;
  logic                blink_r, blink_nxt;
  logic [PeriodW-1:0]  tick_r, tick_nxt;
  logic                write_nxt;
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r;

  fields_t             edited;
  fields_t             loaded;
  logic [PeriodW:0]    tick_inc;
  logic                accept;
  action_t             act;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign act       = action_t'(in_tuser);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign loaded[FldYear]    = in_tdata[6:0];
  assign loaded[FldMonth]   = {3'b000, in_tdata[10:7]};
  assign loaded[FldDay]     = {2'b00, in_tdata[15:11]};
  assign loaded[FldHour]    = {2'b00, in_tdata[20:16]};
  assign loaded[FldMinute]  = {1'b0, in_tdata[26:21]};
  assign loaded[FldSecond]  = {1'b0, in_tdata[32:27]};
  assign loaded[FldWeekday] = {4'b0000, in_tdata[35:33]};

  ctse_edit u_edit (
    .fields_i (fields_r),
    .sel_i    (sel_r),
    .down_i   (act == ACT_DOWN),
    .fields_o (edited)
  );

  assign tick_inc = {1'b0, tick_r} + 17'd1;

  always_comb begin
    fields_nxt = fields_r;
    mode_nxt   = mode_r;
    sel_nxt    = sel_r;
    blink_nxt  = blink_r;
    tick_nxt   = tick_r;
    write_nxt  = 1'b0;
    case (act)
      ACT_TICK: begin
        if (tick_inc >= {1'b0, period_r}) begin
          blink_nxt = !blink_r;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc[PeriodW-1:0];
        end
      end
      ACT_MODE: begin
        if (!mode_r) begin
          mode_nxt = 1'b1;
          sel_nxt  = FldYear;
        end else begin
          mode_nxt  = 1'b0;
          write_nxt = 1'b1;
        end
      end
      ACT_SELECT: begin
        if (mode_r) sel_nxt = (sel_r == FldWeekday) ? FldYear : sel_r + 3'd1;
      end
      ACT_UP, ACT_DOWN: begin
        if (mode_r) fields_nxt = edited;
      end
      ACT_LOAD: begin
        if (!mode_r) fields_nxt = loaded;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= BlinkPeriodRst;
      fields_r    <= '0;
      mode_r      <= 1'b0;
      sel_r       <= '0;
      blink_r     <= 1'b0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) period_r <= cfg_data;
      if (accept) begin
        fields_r    <= fields_nxt;
        mode_r      <= mode_nxt;
        sel_r       <= sel_nxt;
        blink_r     <= blink_nxt;
        tick_r      <= tick_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {1'b0, write_nxt,
                     fields_nxt[FldWeekday], fields_nxt[FldSecond],
                     fields_nxt[FldMinute], fields_nxt[FldHour],
                     fields_nxt[FldDay], fields_nxt[FldMonth],
                     fields_nxt[FldYear], blink_nxt, sel_nxt, mode_nxt};
    end
  end

endmodule
